// ===== src/zsw_pkg.sv =====
// Package for the stored-block zlib wrapper: constants, result slot map and
// the record type passed from the framing stage to the byte emitter.
// Used by zsw_frame, zsw_emit and zlib_stored_block_wrapper.
`default_nettype none

package zsw_pkg;

    localparam int unsigned NUM_SLOTS = 12;
    localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;
    localparam logic [15:0] BLOCK_MAX = 16'hffff;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // Position of each output byte inside one item's record, in stream order.
    localparam logic [SLOT_W-1:0] SLOT_CMF    = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_FLG    = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_BFINAL = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_LEN_LO = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_LEN_HI = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_NLN_LO = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_NLN_HI = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_DATA   = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_SUM3   = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_SUM2   = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_SUM1   = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_SUM0   = 4'd11;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]      mask;
        logic [NUM_SLOTS-1:0][7:0] bytes;
    } zsw_record_t;

endpackage

`default_nettype wire

// ===== src/zsw_frame.sv =====
// Framing stage: stream state, block headers and Adler-32 for each word.
// Builds the record of output bytes for one input word. Depends on zsw_pkg.
`default_nettype none

module zsw_frame
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [31:0]        cfg_wr_data,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    output zsw_pkg::zsw_record_t    record
);

    logic [31:0] total_length_reg;
    logic [15:0] adler_low_reg,  adler_low_next;
    logic [15:0] adler_high_reg, adler_high_next;
    logic [31:0] bytes_done_reg, bytes_done_next;
    logic [15:0] block_left_reg, block_left_next;

    logic        skip;
    logic        new_block;
    logic        stream_end;
    logic        fin;
    logic [31:0] remaining;
    logic [15:0] size;
    logic [15:0] nsize;
    logic [31:0] done_inc;
    logic [16:0] low_sum;
    logic [16:0] low_wrap;
    logic [15:0] low_new;
    logic [16:0] high_sum;
    logic [16:0] high_wrap;
    logic [15:0] high_new;

    always_comb
    begin
        skip       = (bytes_done_reg >= total_length_reg);
        new_block  = (block_left_reg == 16'd0);
        remaining  = total_length_reg - bytes_done_reg;
        fin        = (remaining[31:16] == 16'd0);
        size       = fin ? remaining[15:0] : zsw_pkg::BLOCK_MAX;
        nsize      = ~size;
        done_inc   = bytes_done_reg + 32'd1;
        stream_end = (done_inc >= total_length_reg);

        low_sum   = {1'b0, adler_low_reg} + {9'd0, data_byte};
        low_wrap  = (low_sum >= zsw_pkg::ADLER_MOD) ? low_sum - zsw_pkg::ADLER_MOD : low_sum;
        low_new   = low_wrap[15:0];
        high_sum  = {1'b0, adler_high_reg} + {1'b0, low_new};
        high_wrap = (high_sum >= zsw_pkg::ADLER_MOD) ? high_sum - zsw_pkg::ADLER_MOD
                                                      : high_sum;
        high_new  = high_wrap[15:0];

        record.bytes = '0;
        record.bytes[zsw_pkg::SLOT_CMF]    = zsw_pkg::ZLIB_CMF;
        record.bytes[zsw_pkg::SLOT_FLG]    = zsw_pkg::ZLIB_FLG;
        record.bytes[zsw_pkg::SLOT_BFINAL] = {7'd0, fin};
        record.bytes[zsw_pkg::SLOT_LEN_LO] = size[7:0];
        record.bytes[zsw_pkg::SLOT_LEN_HI] = size[15:8];
        record.bytes[zsw_pkg::SLOT_NLN_LO] = nsize[7:0];
        record.bytes[zsw_pkg::SLOT_NLN_HI] = nsize[15:8];
        record.bytes[zsw_pkg::SLOT_DATA]   = data_byte;
        record.bytes[zsw_pkg::SLOT_SUM3]   = high_new[15:8];
        record.bytes[zsw_pkg::SLOT_SUM2]   = high_new[7:0];
        record.bytes[zsw_pkg::SLOT_SUM1]   = low_new[15:8];
        record.bytes[zsw_pkg::SLOT_SUM0]   = low_new[7:0];

        record.mask = '0;
        if (!skip)
        begin
            record.mask[zsw_pkg::SLOT_CMF]    = (bytes_done_reg == 32'd0);
            record.mask[zsw_pkg::SLOT_FLG]    = (bytes_done_reg == 32'd0);
            record.mask[zsw_pkg::SLOT_BFINAL] = new_block;
            record.mask[zsw_pkg::SLOT_LEN_LO] = new_block;
            record.mask[zsw_pkg::SLOT_LEN_HI] = new_block;
            record.mask[zsw_pkg::SLOT_NLN_LO] = new_block;
            record.mask[zsw_pkg::SLOT_NLN_HI] = new_block;
            record.mask[zsw_pkg::SLOT_DATA]   = 1'b1;
            record.mask[zsw_pkg::SLOT_SUM3]   = stream_end;
            record.mask[zsw_pkg::SLOT_SUM2]   = stream_end;
            record.mask[zsw_pkg::SLOT_SUM1]   = stream_end;
            record.mask[zsw_pkg::SLOT_SUM0]   = stream_end;
        end

        // At the end of a stream every sum and counter returns to its start value.
        if (stream_end)
        begin
            adler_low_next  = 16'd1;
            adler_high_next = 16'd0;
            bytes_done_next = 32'd0;
            block_left_next = 16'd0;
        end
        else
        begin
            adler_low_next  = low_new;
            adler_high_next = high_new;
            bytes_done_next = done_inc;
            block_left_next = (new_block ? size : block_left_reg) - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_length_reg <= 32'd1;
            adler_low_reg    <= 16'd1;
            adler_high_reg   <= 16'd0;
            bytes_done_reg   <= 32'd0;
            block_left_reg   <= 16'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                total_length_reg <= cfg_wr_data;
            end
            if (accept && !skip)
            begin
                adler_low_reg  <= adler_low_next;
                adler_high_reg <= adler_high_next;
                bytes_done_reg <= bytes_done_next;
                block_left_reg <= block_left_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/zsw_emit.sv =====
// Byte emitter: holds one word's record and sends its bytes one per cycle while
// out_ready is high. Takes the next record as its final byte leaves. Depends on zsw_pkg.
`default_nettype none

module zsw_emit
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire zsw_pkg::zsw_record_t record,
    output logic                      can_load,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_byte,
    output logic                      last
);

    logic [zsw_pkg::NUM_SLOTS-1:0]      mask_reg, mask_next;
    logic [zsw_pkg::NUM_SLOTS-1:0][7:0] bytes_reg;
    logic [zsw_pkg::NUM_SLOTS-1:0]      mask_rest;
    logic [zsw_pkg::SLOT_W-1:0]         sel;

    always_comb
    begin
        // Lowest pending slot goes out first.
        sel = zsw_pkg::SLOT_CMF;
        for (int i = zsw_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = zsw_pkg::SLOT_W'(i);
            end
        end

        mask_rest = mask_reg & (mask_reg - zsw_pkg::NUM_SLOTS'(1));
        out_valid = (mask_reg != '0);
        out_byte  = bytes_reg[sel];
        last      = (sel == zsw_pkg::SLOT_SUM0);
        can_load  = (mask_rest == '0) && (!out_valid || out_ready);

        if (load)
        begin
            mask_next = record.mask;
        end
        else if (out_valid && out_ready)
        begin
            mask_next = mask_rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= record.bytes;
        end
    end

endmodule

`default_nettype wire

// ===== src/zlib_stored_block_wrapper.sv =====
// Stored-block zlib wrapper with running Adler-32, top level.
// Instantiates zsw_frame and zsw_emit; depends on zsw_pkg.
//
// Usage: payload bytes enter on data_byte with in_valid/in_ready; zlib stream
// bytes leave on out_byte with out_valid/out_ready, and last marks the final
// checksum byte of each stream. The user must write total_length through
// cfg_wr_en and cfg_wr_data only while the block is idle; the block does not
// enforce this. total_length resets to one byte. Each accepted word is framed
// in the cycle it is taken and its bytes appear on the output from the next
// cycle on. Words that carry only their data byte flow at one word per cycle
// while out_ready is high. A word that opens a block, or a stream, or closes
// a stream, sends up to twelve bytes, as the emitter sends one byte a cycle
// while out_ready is high. The next word is taken in the same cycle as the
// last byte of the previous one leaves. Words past total_length are taken and
// dropped without output. Reset returns the sums and counters to their start
// values and clears the emitter, so nothing is pending. While out_ready is low
// the current byte holds and in_ready stays low unless the emitter is empty.
`default_nettype none

module zlib_stored_block_wrapper
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             last
);

    zsw_pkg::zsw_record_t record;
    logic                 accept;

    assign accept = in_valid && in_ready;

    zsw_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .data_byte   (data_byte),
        .record      (record)
    );

    zsw_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .record    (record),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    // Input may only be taken during an output stall when nothing is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !out_ready) |-> !out_valid)
        else $error("input taken while a stalled byte is pending");

    // The closing checksum byte is always the final byte of its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |-> in_ready)
        else $error("bytes still pending after the closing checksum byte");

    // A stream-closing byte is never followed by more bytes of the same word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last && !in_valid) |=> !out_valid)
        else $error("output continued after the end of a stream");

endmodule

`default_nettype wire

// ===== tb/sv/zlib_stored_block_wrapper_tb.sv =====
// Testbench for zlib_stored_block_wrapper: drives payload words, predicts the
// zlib stored-block stream with its Adler-32 trailer and checks every output word.
// Depends on zsw_pkg and the wrapper RTL; needs no files or arguments.
`default_nettype none

module zlib_stored_block_wrapper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 100_000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 6;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [7:0] val;
        logic       fin;
    } zbyte_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last;

    // Predicted stream state, mirrored from the block's behavior.
    logic [31:0] stream_len;
    logic [15:0] adler_a;
    logic [15:0] adler_b;
    logic [31:0] payload_done;
    logic [15:0] block_owed;

    zbyte_t zlib_bytes_q[$];
    zbyte_t due_byte;
    int     mismatch_count = 0;
    int     framed_words = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     cycle_count = 0;
    logic   holding;
    event   hold_off_ev;

    zlib_stored_block_wrapper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last        (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void queue_zbyte(input logic [7:0] val, input logic fin);
        zbyte_t item;
        item.val = val;
        item.fin = fin;
        zlib_bytes_q.push_back(item);
    endfunction

    function automatic void restart_stream();
        adler_a      = 16'd1;
        adler_b      = 16'd0;
        payload_done = 32'd0;
        block_owed   = 16'd0;
    endfunction

    // Works out the zlib bytes that one accepted payload word produces.
    function automatic bit wrap_payload_byte(input logic [7:0] b);
        logic [31:0] remaining;
        logic [15:0] blk_len;
        logic [16:0] sum_a;
        logic [16:0] sum_b;
        if (payload_done >= stream_len)
            return 1'b0;
        if (payload_done == 32'd0)
        begin
            queue_zbyte(zsw_pkg::ZLIB_CMF, 1'b0);
            queue_zbyte(zsw_pkg::ZLIB_FLG, 1'b0);
        end
        if (block_owed == 16'd0)
        begin
            remaining = stream_len - payload_done;
            blk_len   = (remaining > zsw_pkg::BLOCK_MAX) ? zsw_pkg::BLOCK_MAX
                                                         : remaining[15:0];
            queue_zbyte({7'd0, remaining <= zsw_pkg::BLOCK_MAX}, 1'b0);
            queue_zbyte(blk_len[7:0], 1'b0);
            queue_zbyte(blk_len[15:8], 1'b0);
            queue_zbyte(~blk_len[7:0], 1'b0);
            queue_zbyte(~blk_len[15:8], 1'b0);
            block_owed = blk_len;
        end
        queue_zbyte(b, 1'b0);
        block_owed   = block_owed - 16'd1;
        payload_done = payload_done + 32'd1;
        sum_a = {1'b0, adler_a} + {9'd0, b};
        if (sum_a >= zsw_pkg::ADLER_MOD)
            sum_a = sum_a - zsw_pkg::ADLER_MOD;
        sum_b = {1'b0, adler_b} + sum_a;
        if (sum_b >= zsw_pkg::ADLER_MOD)
            sum_b = sum_b - zsw_pkg::ADLER_MOD;
        adler_a = sum_a[15:0];
        adler_b = sum_b[15:0];
        if (payload_done >= stream_len)
        begin
            queue_zbyte(adler_b[15:8], 1'b0);
            queue_zbyte(adler_b[7:0], 1'b0);
            queue_zbyte(adler_a[15:8], 1'b0);
            queue_zbyte(adler_a[7:0], 1'b1);
            restart_stream();
        end
        return 1'b1;
    endfunction

    // Offers one word and waits until it is taken. Valid stays high afterwards,
    // so the caller either sends again or drains in the same time step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (wrap_payload_byte(b))
            framed_words++;
    endtask

    // Stops offering and waits until every predicted byte has been seen.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (zlib_bytes_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_length(input logic [31:0] len);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        stream_len = len;
    endtask

    task automatic test_reset_length();
        send_byte(8'h00);
        send_byte(8'hff);
        wait_drained();
    endtask

    task automatic test_short_streams();
        set_length(32'd4);
        send_byte(8'haa);
        send_byte(8'h55);
        send_byte(8'h80);
        send_byte(8'h01);
        set_length(32'd2);
        send_byte(8'hff);
        send_byte(8'hff);
        wait_drained();
    endtask

    task automatic test_zero_length();
        set_length(32'd0);
        send_byte(8'h12);
        send_byte(8'hff);
        send_byte(8'h00);
        wait_drained();
    endtask

    // The length register is used live: shrinking it below the words already
    // passed freezes the stream, and growing it again lets the open block finish.
    task automatic test_length_rewrite();
        int i;
        set_length(32'hffff_ffff);
        for (i = 0; i < 12; i++)
            send_byte(8'(i * 37));
        set_length(32'd6);
        send_byte(8'hc3);
        send_byte(8'h3c);
        set_length(32'd15);
        send_byte(8'hfe);
        send_byte(8'h7f);
        send_byte(8'h01);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_length(32'd1);
        -> hold_off_ev;
        for (i = 0; i < 20; i++)
            send_byte($urandom_range(255));
        // Sender pauses here until the output has caught up completely.
        wait_drained();
        for (i = 0; i < 4; i++)
            send_byte($urandom_range(255));
        wait_drained();
    endtask

    task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                       input int quota);
        int start;
        int pick;
        int len;
        int count;
        int i;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = framed_words;
        while (framed_words - start < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                len = 0;
            else if (pick < 16)
                len = $urandom_range(60, 13);
            else
                len = $urandom_range(12, 1);
            // A length at or below the words already passed would freeze the
            // open stream, so it is carried past them instead.
            if (len != 0 && len <= payload_done)
                len = len + int'(payload_done);
            set_length(len);
            if (len == 0)
                count = $urandom_range(3, 1);
            else
            begin
                pick = $urandom_range(99);
                // Mostly whole streams; some cut short, some running into the next.
                if (pick < 10)
                    count = $urandom_range(len - 1, 0);
                else if (pick < 20)
                    count = len + $urandom_range(len, 1);
                else
                    count = len;
            end
            for (i = 0; i < count; i++)
                send_byte($urandom_range(255));
        end
        wait_drained();
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holding)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : hold_off_proc
        int held;
        holding <= 1'b0;
        forever
        begin
            @(hold_off_ev);
            holding <= 1'b1;
            for (held = 0; held < LONG_HOLD; held++)
                @(posedge clk);
            holding <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (zlib_bytes_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: expected no word, got out_byte %02h last %0b",
                             $time, out_byte, last);
            end
            else
            begin
                due_byte = zlib_bytes_q.pop_front();
                if (out_byte !== due_byte.val)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, due_byte.val, out_byte);
                end
                if (last !== due_byte.fin)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: last expected %0b actual %0b",
                                 $time, due_byte.fin, last);
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 32'd0;
        in_valid    <= 1'b0;
        data_byte   <= 8'd0;
        stream_len = 32'd1;
        restart_stream();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_length();
        test_short_streams();
        test_zero_length();
        test_length_rewrite();
        test_backpressure();
        test_random_streams(0, 0, 22);
        test_random_streams(71, 0, 22);
        test_random_streams(0, 71, 22);
        test_random_streams(8, 8, 22);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && zlib_bytes_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
